FILE: rtl/core/frml_pkg.sv
// Package for the frame rate meter and limiter: widths, constants, codes
// and the request and response types of the shared divider.
// No dependencies; imported by frml_div, the unit and its testbench.
package frml_pkg;

  // Window of frame intervals
  localparam int WINDOW_LEN = 1024;
  localparam int SLOT_W     = $clog2(WINDOW_LEN);
  localparam int CNT_W      = $clog2(WINDOW_LEN + 1);

  // Stamps and interval sums
  localparam int STAMP_W = 32;
  localparam int SUM_W   = STAMP_W + SLOT_W;

  // Rate math: fps_q8 = 256000 * count / sum
  localparam longint MS_PER_S_Q8 = 256000;
  localparam int     K_W         = 18;
  localparam int     PROD_W      = K_W + CNT_W;
  localparam int     NUM_W       = $clog2(MS_PER_S_Q8 * WINDOW_LEN + 1);
  localparam int     STEP_W      = $clog2(NUM_W + 1);

  // Frame budget: 1000 / max_fps
  localparam int MS_PER_S = 1000;
  localparam int MS_W     = 10;

  // Result and register fields
  localparam int     FPS_W           = 28;
  localparam int     DELAY_W         = 10;
  localparam longint FPS_MAX         = (64'd1 << FPS_W) - 64'd1;
  localparam int     FALLBACK_FPS_Q8 = 15360;
  localparam int     CMP_W           = (NUM_W > FPS_W) ? NUM_W : FPS_W;
  localparam int     MAXFPS_W        = 16;
  localparam int     MAXFPS_RESET    = 1000;

  // Stream widths
  localparam int S_TDATA_W = STAMP_W;
  localparam int M_TDATA_W = ((FPS_W + DELAY_W + 7) / 8) * 8;

  typedef enum logic {
    KIND_BEGIN = 1'b0,
    KIND_END   = 1'b1
  } kind_e;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [NUM_W-1:0]  num;
    logic [SUM_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

FILE: rtl/core/frml_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module frml_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/frml_div.sv
// Restoring divider, one quotient bit per cycle, shared by the rate and
// budget divisions. Depends on frml_pkg.
module frml_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  frml_pkg::div_req_t req_i,
  output frml_pkg::div_rsp_t rsp_o
);
  import frml_pkg::*;

  logic [STEP_W-1:0] cnt_q;
  logic              done_q;
  logic [NUM_W-1:0]  num_q;
  logic [NUM_W-1:0]  quot_q;
  logic [SUM_W-1:0]  rem_q;
  logic [SUM_W-1:0]  den_q;

  logic [SUM_W:0]    rem_sh;
  logic              ge;
  logic              busy;

  // Shift in the next numerator bit and try the subtract
  assign busy   = (cnt_q != '0);
  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, den_q});

  // Step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      cnt_q  <= req_i.steps;
      done_q <= 1'b0;
    end else if (busy) begin
      cnt_q  <= cnt_q - STEP_W'(1);
      done_q <= (cnt_q == STEP_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath: load operands, then advance one bit per step
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q  <= req_i.num;
      den_q  <= req_i.den;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy) begin
      num_q  <= num_q << 1;
      rem_q  <= ge ? SUM_W'(rem_sh - {1'b0, den_q}) : rem_sh[SUM_W-1:0];
      quot_q <= {quot_q[NUM_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

FILE: rtl/core/frame_rate_meter_limiter_unit.sv
// Frame rate meter and limiter: a frame-end transaction yields one result, and the input
// is not ready again until that result is loaded into the output register; a frame-begin
// transaction only records the frame start. The shared divider computes the rate, then the
// frame budget; the rate division is skipped while the window sum is zero.
// A result still held by the sink stalls the sequencer. Reset clears control state
// and empties the window; the interval RAM is not cleared, as only written entries are read.
module frame_rate_meter_limiter_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration: max_fps
  input  logic                           cfg_wr_en_i,
  input  logic [frml_pkg::MAXFPS_W-1:0]  cfg_wr_data_i,
  // Input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [frml_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [31:0] now_ms
  input  logic                           s_axis_tuser,  // [0] kind
  // Result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [frml_pkg::M_TDATA_W-1:0] m_axis_tdata   // [27:0] fps_q8, [37:28] delay_ms
);
  import frml_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPD,
    S_ADD,
    S_DIVF,
    S_WAITF,
    S_DIVB,
    S_WAITB,
    S_DLY,
    S_OUT
  } state_e;

  state_e              state_q;
  logic [MAXFPS_W-1:0] max_fps_q;
  logic [STAMP_W-1:0]  start_q;
  logic [STAMP_W-1:0]  prev_q;
  logic                seen_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [SUM_W-1:0]    sum_q;
  logic [STAMP_W-1:0]  now_q;
  logic [STAMP_W-1:0]  ivl_q;
  logic [NUM_W-1:0]    prod_q;
  logic [FPS_W-1:0]    fps_q;
  logic [MS_W-1:0]     budget_q;
  logic [DELAY_W-1:0]  delay_q;
  logic                m_valid_q;
  logic [M_TDATA_W-1:0] m_data_q;

  logic                in_fire;
  logic                is_end;
  logic                full;
  logic [STAMP_W-1:0]  ram_rdata;
  logic [PROD_W-1:0]   prod_full;
  logic [MAXFPS_W-1:0] cap;
  logic [STAMP_W-1:0]  spent;
  logic [FPS_W-1:0]    fps_sat;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign is_end        = (kind_e'(s_axis_tuser) == KIND_END);
  assign full          = (cnt_q == CNT_W'(WINDOW_LEN));

  // Interval ring: read the oldest slot on accept, write it in the following cycle
  frml_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (WINDOW_LEN)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (state_q == S_UPD),
    .waddr_i (slot_q),
    .wdata_i (ivl_q),
    .re_i    (in_fire && is_end),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  // Rate numerator, cap, frame time and rate saturation
  assign prod_full = PROD_W'(MS_PER_S_Q8) * PROD_W'(cnt_q);
  assign cap       = (max_fps_q == '0) ? MAXFPS_W'(1) : max_fps_q;
  assign spent     = now_q - start_q;
  assign fps_sat   = (CMP_W'(div_rsp.quot) > CMP_W'(FPS_MAX)) ? FPS_W'(FPS_MAX)
                                                              : FPS_W'(div_rsp.quot);

  // Divider requests: average rate, then frame budget
  always_comb begin
    div_req.start = 1'b0;
    div_req.steps = STEP_W'(NUM_W);
    div_req.num   = prod_q;
    div_req.den   = sum_q;
    unique case (state_q)
      S_DIVF: begin
        div_req.start = (sum_q != '0);
      end
      S_DIVB: begin
        div_req.start = 1'b1;
        div_req.steps = STEP_W'(MS_W);
        div_req.num   = NUM_W'(MS_PER_S) << (NUM_W - MS_W);
        div_req.den   = SUM_W'(cap);
      end
      default: begin
      end
    endcase
  end

  frml_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequencer, window state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      max_fps_q <= MAXFPS_W'(MAXFPS_RESET);
      start_q   <= '0;
      prev_q    <= '0;
      seen_q    <= 1'b0;
      slot_q    <= '0;
      cnt_q     <= '0;
      sum_q     <= '0;
      now_q     <= '0;
      ivl_q     <= '0;
      prod_q    <= '0;
      fps_q     <= '0;
      budget_q  <= '0;
      delay_q   <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        max_fps_q <= cfg_wr_data_i;
      end
      // Load a new result when the register is free, drop it once taken
      if (state_q == S_OUT && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
        m_data_q  <= M_TDATA_W'({delay_q, fps_q});
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (is_end) begin
              now_q   <= s_axis_tdata;
              ivl_q   <= seen_q ? (s_axis_tdata - prev_q) : '0;
              prev_q  <= s_axis_tdata;
              seen_q  <= 1'b1;
              state_q <= S_UPD;
            end else begin
              start_q <= s_axis_tdata;
            end
          end
        end
        S_UPD: begin
          // Retire the oldest interval or grow the window
          if (full) begin
            sum_q <= sum_q - SUM_W'(ram_rdata);
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
          slot_q  <= (slot_q == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_q + SLOT_W'(1);
          state_q <= S_ADD;
        end
        S_ADD: begin
          sum_q   <= sum_q + SUM_W'(ivl_q);
          prod_q  <= NUM_W'(prod_full);
          state_q <= S_DIVF;
        end
        S_DIVF: begin
          if (sum_q == '0) begin
            fps_q   <= FPS_W'(FALLBACK_FPS_Q8);
            state_q <= S_DIVB;
          end else begin
            state_q <= S_WAITF;
          end
        end
        S_WAITF: begin
          if (div_rsp.done) begin
            fps_q   <= fps_sat;
            state_q <= S_DIVB;
          end
        end
        S_DIVB: begin
          state_q <= S_WAITB;
        end
        S_WAITB: begin
          if (div_rsp.done) begin
            budget_q <= MS_W'(div_rsp.quot);
            state_q  <= S_DLY;
          end
        end
        S_DLY: begin
          // Wait only while the frame is still inside its budget
          if (STAMP_W'(budget_q) > spent) begin
            delay_q <= DELAY_W'(budget_q - MS_W'(spent));
          end else begin
            delay_q <= '0;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // The window never holds more intervals than its length
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(WINDOW_LEN))
    else $error("window count beyond window length");

  // An empty window has a zero sum
  a_empty_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (sum_q == '0))
    else $error("nonzero sum with empty window");

  // A frame-begin transaction leaves the block idle
  a_begin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !is_end) |=> (state_q == S_IDLE))
    else $error("begin transaction started a computation");

  // Divider finishes only while the sequencer waits on it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_WAITF || state_q == S_WAITB))
    else $error("divider done outside a wait state");

endmodule

FILE: tb/sv/frame_rate_meter_limiter_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for frame_rate_meter_limiter_unit: drives frame begin/end events,
// predicts the average rate and cap delay per frame end, and checks results.
// Depends on frml_pkg and the unit's RTL only.
module frame_rate_meter_limiter_unit_tb;
  import frml_pkg::*;

  localparam int              CLK_HALF      = 5;
  localparam int              RESET_CYCLES  = 8;
  localparam int              SETTLE_CYCLES = 64;
  localparam int              CYCLE_LIMIT   = 3_000_000;
  localparam int              MAX_REPORTS   = 200;
  localparam longint unsigned RATE_SCALE    = 256000;
  localparam longint unsigned RATE_CEILING  = (64'd1 << FPS_W) - 64'd1;
  localparam longint unsigned RATE_NO_DATA  = 15360;
  localparam int unsigned     MS_PER_SECOND = 1000;

  typedef struct packed {
    logic [FPS_W-1:0]   fps_q8;
    logic [DELAY_W-1:0] delay_ms;
  } fps_report_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_wr_en_i;
  logic [MAXFPS_W-1:0]  cfg_wr_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;   // [31:0] now_ms
  logic                 s_axis_tuser;   // [0] kind
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;   // [27:0] fps_q8, [37:28] delay_ms

  // Rate/cap predictor state
  logic [MAXFPS_W-1:0] fps_cap;
  logic [STAMP_W-1:0]  frame_start;
  logic [STAMP_W-1:0]  last_end_stamp;
  bit                  seen_end;
  logic [STAMP_W-1:0]  interval_ring [WINDOW_LEN];
  int unsigned         ring_slot;
  int unsigned         window_fill;
  longint unsigned     window_total;
  fps_report_t         expected_reports [$];

  // Traffic control and bookkeeping
  logic [STAMP_W-1:0] frame_clock;
  bit                 sender_steady;
  bit                 sink_steady;
  int unsigned        sink_hold_left;
  int unsigned        sink_stall_left;
  int unsigned        cycle_count;
  int unsigned        fault_count;
  int unsigned        begins_sent;
  int unsigned        ends_sent;
  int unsigned        reports_checked;
  int unsigned        cap_writes;

  frame_rate_meter_limiter_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 100 MHz clock
  always begin
    clk_i = 1'b0;
    #CLK_HALF;
    clk_i = 1'b1;
    #CLK_HALF;
  end

  // Mostly short gaps, some medium, a few long
  function automatic int unsigned pick_idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Advance the predictor on one accepted frame event
  task automatic model_frame_event(input kind_e kind, input logic [STAMP_W-1:0] stamp);
    logic [STAMP_W-1:0] interval;
    logic [STAMP_W-1:0] spent;
    int unsigned        budget;
    longint unsigned    rate;
    fps_report_t        rpt;
    if (kind == KIND_BEGIN) begin
      frame_start = stamp;
      return;
    end
    // First end of the run contributes a zero interval
    interval = seen_end ? stamp - last_end_stamp : '0;
    seen_end = 1'b1;
    last_end_stamp = stamp;
    // Full window: oldest interval leaves the sum first
    if (window_fill == WINDOW_LEN) begin
      window_total -= interval_ring[ring_slot];
    end else begin
      window_fill++;
    end
    interval_ring[ring_slot] = interval;
    window_total += interval;
    ring_slot = (ring_slot + 1) % WINDOW_LEN;
    if (window_total == 0) begin
      rate = RATE_NO_DATA;
    end else begin
      rate = (RATE_SCALE * window_fill) / window_total;
      if (rate > RATE_CEILING) rate = RATE_CEILING;
    end
    // Zero cap counts as one frame per second
    budget = MS_PER_SECOND / ((fps_cap == 0) ? 1 : int'(fps_cap));
    spent = stamp - frame_start;
    rpt.fps_q8 = rate[FPS_W-1:0];
    rpt.delay_ms = (budget > spent) ? DELAY_W'(budget - spent) : '0;
    expected_reports.push_back(rpt);
  endtask

  // Offer one frame event and wait for its transaction
  task automatic send_frame_event(input kind_e kind, input logic [STAMP_W-1:0] stamp);
    int unsigned gap;
    gap = sender_steady ? 0 : pick_idle_len();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= stamp;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    model_frame_event(kind, stamp);
    if (kind == KIND_BEGIN) begin
      begins_sent++;
    end else begin
      ends_sent++;
    end
  endtask

  // Drop valid, wait for every expected result, then let the pipeline empty
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write max_fps with the block idle
  task automatic write_fps_cap(input logic [MAXFPS_W-1:0] cap);
    drain_results();
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= cap;
    @(negedge clk_i);
    cfg_wr_en_i <= 1'b0;
    fps_cap = cap;
    cap_writes++;
  endtask

  // Reset-state behavior, cap extremes, stamp wrap, odd event orders
  task automatic test_directed_cases();
    // End before any begin; repeated stamp keeps the sum at zero
    send_frame_event(KIND_END, 32'd0);
    send_frame_event(KIND_END, 32'd0);
    send_frame_event(KIND_BEGIN, 32'd100);
    send_frame_event(KIND_END, 32'd100);
    // Zero cap: stamps wrap across 2^32, end moves backward
    write_fps_cap(16'd0);
    send_frame_event(KIND_BEGIN, 32'hFFFF_FFF0);
    send_frame_event(KIND_END, 32'h0000_0010);
    send_frame_event(KIND_BEGIN, 32'd500);
    send_frame_event(KIND_END, 32'd500);
    send_frame_event(KIND_END, 32'd700);
    send_frame_event(KIND_BEGIN, 32'd800);
    send_frame_event(KIND_BEGIN, 32'd805);
    send_frame_event(KIND_END, 32'd810);
    // Slowest cap, all-ones stamp
    write_fps_cap(16'd1);
    send_frame_event(KIND_BEGIN, 32'hFFFF_FFFF);
    send_frame_event(KIND_END, 32'hFFFF_FFFF);
    // Fastest cap: budget rounds to zero
    write_fps_cap(16'hFFFF);
    send_frame_event(KIND_BEGIN, 32'd1000);
    send_frame_event(KIND_END, 32'd1000);
    // Typical cap: one frame under budget, one over
    write_fps_cap(16'd60);
    send_frame_event(KIND_BEGIN, 32'd2000);
    send_frame_event(KIND_END, 32'd2010);
    send_frame_event(KIND_END, 32'd2030);
    write_fps_cap(16'(MAXFPS_RESET));
    send_frame_event(KIND_END, 32'd2040);
    frame_clock = 32'd2040;
    drain_results();
  endtask

  // Hold the result side while the sender keeps offering frames
  task automatic test_result_backpressure();
    sender_steady  = 1'b1;
    sink_hold_left = 1500;
    repeat (12) begin
      frame_clock += $urandom_range(1, 4);
      send_frame_event(KIND_BEGIN, frame_clock);
      frame_clock += $urandom_range(0, 20);
      send_frame_event(KIND_END, frame_clock);
    end
    sender_steady = 1'b0;
    drain_results();
  endtask

  // Push frame ends that, with those of the earlier tests, fill the window and evict old intervals
  task automatic test_window_wrap();
    int unsigned roll;
    write_fps_cap(16'd120);
    for (int unsigned i = 0; i < 1040; i++) begin
      roll = $urandom_range(0, 99);
      if (i % 50 == 49) begin
        send_frame_event(KIND_BEGIN, frame_clock);
      end else begin
        frame_clock += (roll < 95) ? $urandom_range(1, 30) : $urandom_range(100, 5000);
        send_frame_event(KIND_END, frame_clock);
      end
    end
    drain_results();
  endtask

  // Mostly well-formed frames with random timing, plus odd orders and stray stamps
  task automatic test_random_frames(input int unsigned items, input logic [MAXFPS_W-1:0] cap,
                                    input bit steady_send, input bit steady_sink);
    int unsigned        sent;
    int unsigned        roll;
    logic [STAMP_W-1:0] stray;
    write_fps_cap(cap);
    sender_steady = steady_send;
    sink_steady   = steady_sink;
    sent = 0;
    while (sent < items) begin
      roll = $urandom_range(0, 99);
      if (roll < 78) begin
        frame_clock += $urandom_range(0, 3);
        send_frame_event(KIND_BEGIN, frame_clock);
        frame_clock += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2000)
                                                  : $urandom_range(0, 40);
        send_frame_event(KIND_END, frame_clock);
        sent += 2;
      end else if (roll < 88) begin
        // end with no fresh begin
        frame_clock += $urandom_range(0, 40);
        send_frame_event(KIND_END, frame_clock);
        sent++;
      end else if (roll < 95) begin
        // restarted frame: two begins in a row
        send_frame_event(KIND_BEGIN, frame_clock);
        frame_clock += $urandom_range(0, 10);
        send_frame_event(KIND_BEGIN, frame_clock);
        sent += 2;
      end else begin
        stray = $urandom();
        send_frame_event(kind_e'($urandom_range(0, 1)), stray);
        if ($urandom_range(0, 1) == 1) frame_clock = stray;
        sent++;
      end
    end
    sender_steady = 1'b0;
    sink_steady   = 1'b0;
    drain_results();
  endtask

  // Result side: long hold-off on request, else random stalls unless the sink is steady
  initial begin : result_sink
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_left > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold_left--;
      end else if (sink_stall_left > 0) begin
        m_axis_tready <= 1'b0;
        sink_stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!sink_steady && $urandom_range(0, 2) == 0) sink_stall_left = pick_idle_len();
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin : check_results
    fps_report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_reports.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual tdata 0x%0h",
                   $time, m_axis_tdata);
      end else begin
        want = expected_reports.pop_front();
        reports_checked++;
        if (m_axis_tdata[FPS_W-1:0] !== want.fps_q8) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("%0t: fps_q8 mismatch, expected %0d, actual %0d",
                     $time, want.fps_q8, m_axis_tdata[FPS_W-1:0]);
        end
        if (m_axis_tdata[FPS_W+DELAY_W-1:FPS_W] !== want.delay_ms) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("%0t: delay_ms mismatch, expected %0d, actual %0d",
                     $time, want.delay_ms, m_axis_tdata[FPS_W+DELAY_W-1:FPS_W]);
        end
      end
    end
  end

  // Abort a hung run
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding",
             cycle_count, expected_reports.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin : run_tests
    rst_ni          = 1'b0;
    cfg_wr_en_i     = 1'b0;
    cfg_wr_data_i   = '0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = 1'b0;
    fps_cap         = MAXFPS_W'(MAXFPS_RESET);
    frame_start     = '0;
    last_end_stamp  = '0;
    seen_end        = 1'b0;
    ring_slot       = 0;
    window_fill     = 0;
    window_total    = 0;
    frame_clock     = '0;
    sender_steady   = 1'b0;
    sink_steady     = 1'b0;
    sink_hold_left  = 0;
    sink_stall_left = 0;
    fault_count     = 0;
    begins_sent     = 0;
    ends_sent       = 0;
    reports_checked = 0;
    cap_writes      = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_result_backpressure();
    test_window_wrap();
    frame_clock = $urandom();
    test_random_frames(36, 16'd60, 1'b0, 1'b0);
    test_random_frames(36, 16'd1, 1'b1, 1'b0);
    test_random_frames(36, 16'hFFFF, 1'b0, 1'b1);
    test_random_frames(36, 16'($urandom_range(2, 240)), 1'b0, 1'b0);
    test_random_frames(36, 16'($urandom()), 1'b0, 1'b0);

    $display("Ran %0d frame begins and %0d frame ends, checked %0d rate results",
             begins_sent, ends_sent, reports_checked);
    $display("Wrote the fps cap %0d times; the %0d-entry window filled and rolled over",
             cap_writes, WINDOW_LEN);
    if (fault_count == 0 && expected_reports.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
